@@ hdl/priority_queue_severity_arrival_assert.svh @@
// Assertion macros used by the priority queue top module.
`ifndef PRIORITY_QUEUE_SEVERITY_ARRIVAL_ASSERT_SVH
`define PRIORITY_QUEUE_SEVERITY_ARRIVAL_ASSERT_SVH

// Checks a consequent in the same cycle as its antecedent.
`define PQSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequent in the cycle after its antecedent.
`define PQSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pqsa_pkg.sv @@
// Types and constants of the severity and arrival priority queue.
package pqsa_pkg;

  localparam int unsigned Capacity     = 16;
  localparam int unsigned SeverityBits = 8;
  localparam int unsigned ArrivalBits  = 11;
  localparam int unsigned TagBits      = 16;
  localparam int unsigned CntBits      = $clog2(Capacity + 1);

  typedef enum logic [0:0] {
    OpInsert = 1'b0,
    OpPop    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StPopped   = 2'd1,
    StEmpty    = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef struct packed {
    op_e                     op;
    logic [SeverityBits-1:0] severity;
    logic [ArrivalBits-1:0]  arrival_minutes;
    logic [TagBits-1:0]      tag;
  } in_word_t;

  typedef struct packed {
    status_e                 status;
    logic [SeverityBits-1:0] out_severity;
    logic [ArrivalBits-1:0]  out_arrival;
    logic [TagBits-1:0]      out_tag;
    logic [CntBits-1:0]      occupancy;
  } out_word_t;

  typedef struct packed {
    logic [SeverityBits-1:0] sev;
    logic [ArrivalBits-1:0]  arr;
    logic [TagBits-1:0]      tag;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

  // True when entry a must leave the queue strictly before entry b.
  function automatic logic more_urgent(entry_t a, entry_t b);
    logic res;
    if (a.sev != b.sev) begin
      res = (a.sev > b.sev);
    end else begin
      res = (a.arr < b.arr);
    end
    return res;
  endfunction

endpackage

@@ hdl/pqsa_cell.sv @@
// One slot of the sorted entry chain, shifting toward the head on pop.
module pqsa_cell (
  input  logic              clk_i,
  input  pqsa_pkg::cell_ctl_t ctl_i,
  input  logic              occupied_i,
  input  logic              beats_left_i,
  input  pqsa_pkg::entry_t  new_i,
  input  pqsa_pkg::entry_t  left_i,
  input  pqsa_pkg::entry_t  right_i,
  output pqsa_pkg::entry_t  entry_o,
  output logic              beats_o
);
  import pqsa_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  // A new entry displaces this slot when the slot is free or strictly less urgent,
  // so equal keys keep their insertion order.
  assign beats_o = !occupied_i || more_urgent(new_i, entry_q);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.pop) begin
      entry_d = right_i;
    end else if (ctl_i.ins) begin
      if (beats_left_i) begin
        entry_d = left_i;
      end else if (beats_o) begin
        entry_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ hdl/priority_queue_severity_arrival.sv @@
// Bounded priority queue built as a sorted chain of entry cells.
//
// Input channel in_valid_i/in_ready_o carries one word per item: an insert
// of (severity, arrival_minutes, tag) or a pop of the most urgent entry.
// Output channel out_valid_o/out_ready_i returns exactly one word per item
// with a status, the popped entry (zeros unless popped) and the occupancy.
// The cells stay sorted, highest severity then earliest arrival at the head;
// an insert is placed behind all entries of equal key.
// An accepted word waits in the command register until the output register is
// free; then every cell updates at once and the result is loaded into the
// output register. A new word is taken only once the held word has been
// applied, so the single command register limits the flow of items.
// While a result waits for out_ready_i, the next word may still be taken
// into the command register; it is applied only once the output is free.
// Reset empties the queue; the cell contents are not cleared.
module priority_queue_severity_arrival (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pqsa_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pqsa_pkg::out_word_t out_word_o
);
  import pqsa_pkg::*;

  `include "priority_queue_severity_arrival_assert.svh"

  logic               busy_q, busy_d;
  in_word_t           cmd_q;
  logic [CntBits-1:0] count_q, count_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_q, out_d;
  logic               fire;
  cell_ctl_t          ctl;
  entry_t             new_entry;
  entry_t             out_entry;
  entry_t             cell_entry [Capacity];
  logic               cell_beats [Capacity];

  assign in_ready_o  = !busy_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign fire = busy_q && (!out_valid_q || out_ready_i);

  assign new_entry.sev = cmd_q.severity;
  assign new_entry.arr = cmd_q.arrival_minutes;
  assign new_entry.tag = cmd_q.tag;

  assign out_entry.sev = out_q.out_severity;
  assign out_entry.arr = out_q.out_arrival;
  assign out_entry.tag = out_q.out_tag;

  always_comb begin
    ctl.ins = fire && (cmd_q.op == OpInsert) && (count_q < CntBits'(Capacity));
    ctl.pop = fire && (cmd_q.op == OpPop) && (count_q != '0);
  end

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    pqsa_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occupied_i  (count_q > CntBits'(i)),
      .beats_left_i((i == 0) ? 1'b0 : cell_beats[(i == 0) ? 0 : i - 1]),
      .new_i       (new_entry),
      .left_i      (cell_entry[(i == 0) ? 0 : i - 1]),
      .right_i     (cell_entry[(i == Capacity - 1) ? i : i + 1]),
      .entry_o     (cell_entry[i]),
      .beats_o     (cell_beats[i])
    );
  end

  always_comb begin
    busy_d      = busy_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      busy_d = 1'b1;
    end
    if (fire) begin
      busy_d       = 1'b0;
      out_valid_d  = 1'b1;
      out_d        = '0;
      if (ctl.ins) begin
        count_d = count_q + CntBits'(1);
        out_d.status = StInserted;
      end else if (ctl.pop) begin
        count_d = count_q - CntBits'(1);
        out_d.status       = StPopped;
        out_d.out_severity = cell_entry[0].sev;
        out_d.out_arrival  = cell_entry[0].arr;
        out_d.out_tag      = cell_entry[0].tag;
      end else if (cmd_q.op == OpPop) begin
        out_d.status = StEmpty;
      end else begin
        out_d.status = StFull;
      end
      out_d.occupancy = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= in_word_i;
    end
    out_q <= out_d;
  end

  `PQSA_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntBits'(Capacity),
    "Entry count exceeds the capacity.")
  `PQSA_ASSERT_NEXT(a_insert_count, ctl.ins, count_q == $past(count_q) + CntBits'(1),
    "Accepted insert did not grow the entry count by one.")
  `PQSA_ASSERT_NEXT(a_pop_order, ctl.pop,
    (count_q == '0) || !more_urgent(cell_entry[0], out_entry),
    "Popped word was less urgent than the new head of the queue.")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the severity and arrival priority queue.
module testbench;
  import pqsa_pkg::*;

  localparam int unsigned RandomWords = 1300;
  localparam int unsigned LimitCycles = 600000;
  localparam int unsigned DrainCycles = 20000;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t result;
  } vector_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_word_t  in_word_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_word_t out_word_o;

  entry_t      shadow_entries[Capacity];
  int unsigned shadow_count = 0;
  out_word_t   awaited_results[$];
  int unsigned error_count = 0;
  vector_t     vectors[$];
  bit          sender_quiet = 1'b0;

  priority_queue_severity_arrival u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #(LimitCycles * 12);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic out_word_t predict_urgency(in_word_t w);
    out_word_t   r;
    int unsigned best;
    r = '0;
    if (w.op == OpInsert) begin
      if (shadow_count >= Capacity) begin
        r.status = StFull;
      end else begin
        shadow_entries[shadow_count].sev = w.severity;
        shadow_entries[shadow_count].arr = w.arrival_minutes;
        shadow_entries[shadow_count].tag = w.tag;
        shadow_count++;
        r.status = StInserted;
      end
    end else if (shadow_count == 0) begin
      r.status = StEmpty;
    end else begin
      best = 0;
      for (int unsigned i = 1; i < shadow_count; i++) begin
        if (shadow_entries[i].sev > shadow_entries[best].sev ||
            (shadow_entries[i].sev == shadow_entries[best].sev &&
             shadow_entries[i].arr < shadow_entries[best].arr)) begin
          best = i;
        end
      end
      r.status       = StPopped;
      r.out_severity = shadow_entries[best].sev;
      r.out_arrival  = shadow_entries[best].arr;
      r.out_tag      = shadow_entries[best].tag;
      for (int unsigned i = best; i + 1 < shadow_count; i++) begin
        shadow_entries[i] = shadow_entries[i + 1];
      end
      shadow_count--;
    end
    r.occupancy = CntBits'(shadow_count);
    return r;
  endfunction

  function automatic in_word_t insert_word(logic [SeverityBits-1:0] s,
                                           logic [ArrivalBits-1:0] a,
                                           logic [TagBits-1:0] t);
    in_word_t w;
    w.op              = OpInsert;
    w.severity        = s;
    w.arrival_minutes = a;
    w.tag             = t;
    return w;
  endfunction

  function automatic in_word_t pop_word(bit ones);
    in_word_t w;
    w    = ones ? '1 : '0;
    w.op = OpPop;
    return w;
  endfunction

  function automatic out_word_t result_word(status_e st, logic [SeverityBits-1:0] s,
                                            logic [ArrivalBits-1:0] a,
                                            logic [TagBits-1:0] t, int unsigned occ);
    out_word_t r;
    r.status       = st;
    r.out_severity = s;
    r.out_arrival  = a;
    r.out_tag      = t;
    r.occupancy    = CntBits'(occ);
    return r;
  endfunction

  function automatic in_word_t random_word(int unsigned insert_pct);
    in_word_t w;
    w.op = ($urandom_range(0, 99) < insert_pct) ? OpInsert : OpPop;
    if ($urandom_range(0, 1) == 0) begin
      w.severity        = SeverityBits'($urandom_range(0, 3));
      w.arrival_minutes = ArrivalBits'($urandom_range(0, 3));
    end else begin
      w.severity        = SeverityBits'($urandom_range(0, 255));
      w.arrival_minutes = ArrivalBits'($urandom_range(0, 2047));
    end
    w.tag = TagBits'($urandom_range(0, 65535));
    return w;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic offer_word(in_word_t w, bit typed, out_word_t typed_result);
    out_word_t   predicted;
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_urgency(w);
    awaited_results.push_back(typed ? typed_result : predicted);
    gap = sender_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic check_result(out_word_t got);
    out_word_t want;
    if (awaited_results.size() == 0) begin
      error_count++;
      if (error_count <= 10) begin
        $display("Unexpected result word %h with nothing awaited.", got);
      end
    end else begin
      want = awaited_results.pop_front();
      if (got.status !== want.status || got.out_severity !== want.out_severity ||
          got.out_arrival !== want.out_arrival || got.out_tag !== want.out_tag ||
          got.occupancy !== want.occupancy) begin
        error_count++;
        if (error_count <= 10) begin
          $display("Mismatch: expected st %0d sev %0d arr %0d tag %h occ %0d",
                   want.status, want.out_severity, want.out_arrival, want.out_tag,
                   want.occupancy);
          $display("          got      st %0d sev %0d arr %0d tag %h occ %0d",
                   got.status, got.out_severity, got.out_arrival, got.out_tag,
                   got.occupancy);
        end
      end
    end
  endtask

  initial begin
    int unsigned stall;
    int unsigned cycle;
    bit          quiet;
    stall = 0;
    cycle = 0;
    quiet = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        check_result(out_word_o);
      end
      cycle++;
      if (cycle % 200 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        stall = quiet ? 0 : pick_gap();
        if (stall > 0) begin
          stall--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  initial begin
    out_word_t   none;
    int unsigned insert_pct;
    none       = '0;
    insert_pct = 50;

    vectors.push_back('{pop_word(1'b1), 1'b1, result_word(StEmpty, '0, '0, '0, 0)});
    vectors.push_back('{insert_word(8'hFF, 11'h7FF, 16'hFFFF), 1'b1,
                        result_word(StInserted, '0, '0, '0, 1)});
    vectors.push_back('{insert_word(8'hFF, 11'h000, 16'h0001), 1'b1,
                        result_word(StInserted, '0, '0, '0, 2)});
    vectors.push_back('{insert_word(8'hFF, 11'h000, 16'h0002), 1'b1,
                        result_word(StInserted, '0, '0, '0, 3)});
    vectors.push_back('{insert_word(8'h00, 11'h000, 16'h0000), 1'b1,
                        result_word(StInserted, '0, '0, '0, 4)});
    vectors.push_back('{insert_word(8'h00, 11'h7FF, 16'hFFFF), 1'b1,
                        result_word(StInserted, '0, '0, '0, 5)});
    vectors.push_back('{insert_word(8'h80, 11'd1439, 16'h5A5A), 1'b1,
                        result_word(StInserted, '0, '0, '0, 6)});
    vectors.push_back('{insert_word(8'h80, 11'd1440, 16'hA5A5), 1'b1,
                        result_word(StInserted, '0, '0, '0, 7)});
    vectors.push_back('{insert_word(8'h7F, 11'h400, 16'h8000), 1'b1,
                        result_word(StInserted, '0, '0, '0, 8)});
    vectors.push_back('{insert_word(8'h01, 11'h3FF, 16'h7FFF), 1'b1,
                        result_word(StInserted, '0, '0, '0, 9)});
    vectors.push_back('{insert_word(8'h55, 11'h555, 16'h5555), 1'b1,
                        result_word(StInserted, '0, '0, '0, 10)});
    vectors.push_back('{insert_word(8'hAA, 11'h2AA, 16'hAAAA), 1'b1,
                        result_word(StInserted, '0, '0, '0, 11)});
    for (int unsigned i = 0; i < 5; i++) begin
      vectors.push_back('{insert_word(8'h80, 11'd1439, TagBits'(16'h0100 + i)), 1'b1,
                          result_word(StInserted, '0, '0, '0, 12 + i)});
    end
    vectors.push_back('{insert_word(8'hFF, 11'h000, 16'hDEAD), 1'b1,
                        result_word(StFull, '0, '0, '0, 16)});
    vectors.push_back('{pop_word(1'b0), 1'b1,
                        result_word(StPopped, 8'hFF, 11'h000, 16'h0001, 15)});
    vectors.push_back('{pop_word(1'b1), 1'b1,
                        result_word(StPopped, 8'hFF, 11'h000, 16'h0002, 14)});
    for (int unsigned i = 0; i < 5; i++) begin
      vectors.push_back('{pop_word(i[0]), 1'b0, none});
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (vectors[i]) begin
      offer_word(vectors[i].word, vectors[i].typed, vectors[i].result);
    end

    for (int unsigned n = 0; n < RandomWords; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 80;
          1: insert_pct = 20;
          default: insert_pct = 50;
        endcase
      end
      if (n % 64 == 0) begin
        sender_quiet = ($urandom_range(0, 3) == 0);
      end
      if (n == RandomWords / 3 || n == 2 * RandomWords / 3) begin
        in_valid_i <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      offer_word(random_word(insert_pct), 1'b0, none);
    end
    in_valid_i <= 1'b0;

    for (int unsigned i = 0; i < DrainCycles && awaited_results.size() != 0; i++) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    error_count += awaited_results.size();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/pqsa_pkg.sv
hdl/pqsa_cell.sv
hdl/priority_queue_severity_arrival.sv
verif/testbench.sv
